// ===== src/obc_pkg.sv =====
// Shared package for the online bridge counter.
// Holds default parameters, field widths, edge kind codes and the command and status types.
// Depends on nothing.
`default_nettype none

package obc_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_STAMP_BITS   = 16;
    localparam int VTX_W            = 10;
    localparam int CNT_W            = 10;
    localparam int KIND_W           = 2;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRIDGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CYCLE  = 2'd2;

    typedef enum logic [5:0] {
        CMD_NOP, CMD_INIT, CMD_ACCEPT,
        CMD_ER_A, CMD_ER_B, CMD_ER_C, CMD_ER_D,
        CMD_FU, CMD_FV,
        CMD_C1, CMD_C2, CMD_C2B, CMD_C3, CMD_C4, CMD_C5, CMD_CU, CMD_CV,
        CMD_SZ1, CMD_SZ2,
        CMD_R1, CMD_R2, CMD_R3, CMD_R4, CMD_R5,
        CMD_J1, CMD_J2, CMD_J3,
        CMD_M0, CMD_MS, CMD_M1,
        CMD_MA0, CMD_MA1, CMD_MA2, CMD_MA3,
        CMD_MB0, CMD_MB1, CMD_MB2, CMD_MB3,
        CMD_MCHK,
        CMD_PA0, CMD_PA1, CMD_PB0, CMD_PB1,
        CMD_DONE
    } t_cmd;

    typedef struct packed {
        logic cond;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/obc_ctrl.sv =====
// Controller state machine of the online bridge counter.
// Sequences finds, component merges, rerooting and cycle walks; uses obc_pkg.
`default_nettype none

module obc_ctrl
    import obc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    localparam logic [5:0] S_INIT = 6'd0,  S_IDLE = 6'd1,  S_ER_A = 6'd2,  S_ER_B = 6'd3;
    localparam logic [5:0] S_ER_C = 6'd4,  S_ER_D = 6'd5,  S_FU   = 6'd6,  S_FV   = 6'd7;
    localparam logic [5:0] S_C1   = 6'd8,  S_C2   = 6'd9,  S_C2B  = 6'd10, S_C3   = 6'd11;
    localparam logic [5:0] S_C4   = 6'd12, S_C5   = 6'd13, S_CU   = 6'd14, S_CV   = 6'd15;
    localparam logic [5:0] S_SZ1  = 6'd16, S_SZ2  = 6'd17, S_R1   = 6'd18, S_R2   = 6'd19;
    localparam logic [5:0] S_R3   = 6'd20, S_R4   = 6'd21, S_R5   = 6'd22, S_J1   = 6'd23;
    localparam logic [5:0] S_J2   = 6'd24, S_J3   = 6'd25, S_M0   = 6'd26, S_MS   = 6'd27;
    localparam logic [5:0] S_M1   = 6'd28, S_MA0  = 6'd29, S_MA1  = 6'd30, S_MA2  = 6'd31;
    localparam logic [5:0] S_MA3  = 6'd32, S_MB0  = 6'd33, S_MB1  = 6'd34, S_MB2  = 6'd35;
    localparam logic [5:0] S_MB3  = 6'd36, S_MCHK = 6'd37, S_PA0  = 6'd38, S_PA1  = 6'd39;
    localparam logic [5:0] S_PB0  = 6'd40, S_PB1  = 6'd41, S_DONE = 6'd42;

    logic [5:0] r_state, n_state;
    logic [5:0] r_ret, n_ret;
    logic [5:0] r_cret, n_cret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_IDLE;
            r_cret  <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cret  <= n_cret;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cret  = r_cret;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            S_INIT: begin
                o_cmd = CMD_INIT;
                if (i_stat.cond) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_ACCEPT;
                    if (i_stat.cond) begin
                        n_ret   = S_FU;
                        n_state = S_ER_A;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ER_A: begin o_cmd = CMD_ER_A; n_state = S_ER_B; end
            S_ER_B: begin
                o_cmd   = CMD_ER_B;
                n_state = i_stat.cond ? S_ER_C : S_ER_A;
            end
            S_ER_C: begin
                o_cmd   = CMD_ER_C;
                n_state = i_stat.cond ? r_ret : S_ER_D;
            end
            S_ER_D: begin
                o_cmd   = CMD_ER_D;
                n_state = i_stat.cond ? r_ret : S_ER_C;
            end
            S_FU: begin
                o_cmd   = CMD_FU;
                n_ret   = S_FV;
                n_state = S_ER_A;
            end
            S_FV: begin
                o_cmd  = CMD_FV;
                n_cret = S_CU;
                n_state = i_stat.cond ? S_DONE : S_C1;
            end
            S_C1: begin o_cmd = CMD_C1; n_state = S_C2; end
            S_C2: begin
                o_cmd = CMD_C2;
                if (i_stat.cond) begin
                    n_state = S_C3;
                end else begin
                    n_ret   = S_C2B;
                    n_state = S_ER_A;
                end
            end
            S_C2B: begin o_cmd = CMD_C2B; n_state = S_C1; end
            S_C3: begin o_cmd = CMD_C3; n_state = S_C4; end
            S_C4: begin
                o_cmd = CMD_C4;
                if (i_stat.cond) begin
                    n_state = r_cret;
                end else begin
                    n_ret   = S_C5;
                    n_state = S_ER_A;
                end
            end
            S_C5: begin o_cmd = CMD_C5; n_state = S_C3; end
            S_CU: begin
                o_cmd   = CMD_CU;
                n_cret  = S_CV;
                n_state = S_C1;
            end
            S_CV: begin
                o_cmd   = CMD_CV;
                n_state = i_stat.cond ? S_M0 : S_SZ1;
            end
            S_SZ1: begin o_cmd = CMD_SZ1; n_state = S_SZ2; end
            S_SZ2: begin o_cmd = CMD_SZ2; n_state = S_R1; end
            S_R1: begin o_cmd = CMD_R1; n_state = S_R2; end
            S_R2: begin
                o_cmd = CMD_R2;
                if (i_stat.cond) begin
                    n_state = S_R3;
                end else begin
                    n_ret   = S_R3;
                    n_state = S_ER_A;
                end
            end
            S_R3: begin
                o_cmd   = CMD_R3;
                n_state = i_stat.cond ? S_R4 : S_R1;
            end
            S_R4: begin o_cmd = CMD_R4; n_state = S_R5; end
            S_R5: begin o_cmd = CMD_R5; n_state = S_J1; end
            S_J1: begin o_cmd = CMD_J1; n_state = S_J2; end
            S_J2: begin o_cmd = CMD_J2; n_state = S_J3; end
            S_J3: begin o_cmd = CMD_J3; n_state = S_DONE; end
            S_M0: begin
                o_cmd   = CMD_M0;
                n_state = i_stat.cond ? S_MS : S_M1;
            end
            S_MS: begin
                o_cmd = CMD_MS;
                if (i_stat.cond) n_state = S_M1;
            end
            S_M1: begin o_cmd = CMD_M1; n_state = S_MA0; end
            S_MA0: begin
                o_cmd = CMD_MA0;
                if (i_stat.cond) begin
                    n_state = S_MB0;
                end else begin
                    n_ret   = S_MA1;
                    n_state = S_ER_A;
                end
            end
            S_MA1: begin o_cmd = CMD_MA1; n_state = S_MA2; end
            S_MA2: begin
                o_cmd   = CMD_MA2;
                n_state = i_stat.cond ? S_PA0 : S_MA3;
            end
            S_MA3: begin o_cmd = CMD_MA3; n_state = S_MB0; end
            S_MB0: begin
                o_cmd = CMD_MB0;
                if (i_stat.cond) begin
                    n_state = S_MCHK;
                end else begin
                    n_ret   = S_MB1;
                    n_state = S_ER_A;
                end
            end
            S_MB1: begin o_cmd = CMD_MB1; n_state = S_MB2; end
            S_MB2: begin
                o_cmd   = CMD_MB2;
                n_state = i_stat.cond ? S_PA0 : S_MB3;
            end
            S_MB3: begin o_cmd = CMD_MB3; n_state = S_MCHK; end
            S_MCHK: begin
                o_cmd   = CMD_MCHK;
                n_state = i_stat.cond ? S_DONE : S_MA0;
            end
            S_PA0: begin
                o_cmd   = CMD_PA0;
                n_state = i_stat.cond ? S_PB0 : S_PA1;
            end
            S_PA1: begin
                o_cmd   = CMD_PA1;
                n_state = i_stat.cond ? S_PB0 : S_PA0;
            end
            S_PB0: begin
                o_cmd   = CMD_PB0;
                n_state = i_stat.cond ? S_DONE : S_PB1;
            end
            S_PB1: begin
                o_cmd   = CMD_PB1;
                n_state = i_stat.cond ? S_DONE : S_PB0;
            end
            S_DONE: begin
                o_cmd = CMD_DONE;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/obc_dp.sv =====
// Datapath of the online bridge counter: link, size, parent, stamp and path memories.
// Carries out one command per cycle from obc_ctrl and returns status; uses obc_pkg.
`default_nettype none

module obc_dp
    import obc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int STAMP_BITS   = DEF_STAMP_BITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    input  wire [VTX_W-1:0]   i_first_vertex,
    input  wire [VTX_W-1:0]   i_second_vertex,
    input  wire               i_out_stall,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [CNT_W-1:0]  o_bridge_count,
    output logic [KIND_W-1:0] o_edge_kind
);

    localparam int VW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = VW + 1;
    localparam int SB = STAMP_BITS;

    logic [VW:0]   m_tp  [0:MAX_VERTICES-1];
    logic [VW-1:0] m_ecc [0:MAX_VERTICES-1];
    logic [VW-1:0] m_cc  [0:MAX_VERTICES-1];
    logic [NW-1:0] m_sz  [0:MAX_VERTICES-1];
    logic [SB-1:0] m_st  [0:MAX_VERTICES-1];
    logic [VW-1:0] m_pa  [0:MAX_VERTICES-1];
    logic [VW-1:0] m_pb  [0:MAX_VERTICES-1];

    logic          tp_we, ecc_we, cc_we, sz_we, st_we, pa_we, pb_we;
    logic [VW-1:0] tp_wa, ecc_wa, cc_wa, sz_wa, st_wa, pa_wa, pb_wa;
    logic [VW-1:0] tp_ra, ecc_ra, cc_ra, sz_ra, st_ra, pa_ra, pb_ra;
    logic [VW:0]   tp_wd, tp_q;
    logic [VW-1:0] ecc_wd, ecc_q, cc_wd, cc_q, pa_wd, pa_q, pb_wd, pb_q;
    logic [NW-1:0] sz_wd, sz_q;
    logic [SB-1:0] st_wd, st_q;

    logic [VW-1:0] r_fx, n_fx, r_fr, n_fr, r_u, n_u, r_v, n_v, r_cu, n_cu, r_cv, n_cv;
    logic [VW-1:0] r_cr, n_cr, r_cx, n_cx, r_cy, n_cy, r_rv, n_rv, r_child, n_child;
    logic [VW-1:0] r_a, n_a, r_b, n_b, r_lca, n_lca, r_clr, n_clr;
    logic [NW-1:0] r_szu, n_szu, r_na, n_na, r_nb, n_nb, r_i, n_i, r_bridges, n_bridges;
    logic          r_child_none, n_child_none, r_pnone, n_pnone;
    logic          r_a_none, n_a_none, r_b_none, n_b_none;
    logic [SB-1:0] r_walk, n_walk, walk_inc;
    logic [KIND_W-1:0] r_kind, n_kind, r_out_kind, n_out_kind;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic              r_out_valid, n_out_valid;
    logic              clr_last, out_free, in_range;
    logic [NW-1:0]     drop_val;

    always_ff @(posedge i_clk) begin
        if (tp_we) m_tp[tp_wa] <= tp_wd;
        tp_q <= m_tp[tp_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ecc_we) m_ecc[ecc_wa] <= ecc_wd;
        ecc_q <= m_ecc[ecc_ra];
    end
    always_ff @(posedge i_clk) begin
        if (cc_we) m_cc[cc_wa] <= cc_wd;
        cc_q <= m_cc[cc_ra];
    end
    always_ff @(posedge i_clk) begin
        if (sz_we) m_sz[sz_wa] <= sz_wd;
        sz_q <= m_sz[sz_ra];
    end
    always_ff @(posedge i_clk) begin
        if (st_we) m_st[st_wa] <= st_wd;
        st_q <= m_st[st_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pa_we) m_pa[pa_wa] <= pa_wd;
        pa_q <= m_pa[pa_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pb_we) m_pb[pb_wa] <= pb_wd;
        pb_q <= m_pb[pb_ra];
    end

    assign walk_inc = r_walk + 1'b1;
    assign clr_last = (r_clr == VW'(MAX_VERTICES - 1));
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = (32'(i_first_vertex) < MAX_VERTICES)
                   && (32'(i_second_vertex) < MAX_VERTICES);
    assign drop_val = (r_bridges != '0) ? (r_bridges - 1'b1) : r_bridges;

    assign o_out_valid     = r_out_valid;
    assign o_bridge_count  = r_out_cnt;
    assign o_edge_kind     = r_out_kind;

    always_comb begin
        tp_we = 1'b0; ecc_we = 1'b0; cc_we = 1'b0; sz_we = 1'b0;
        st_we = 1'b0; pa_we = 1'b0; pb_we = 1'b0;
        tp_wa = r_clr; ecc_wa = r_clr; cc_wa = r_clr; sz_wa = r_clr;
        st_wa = r_clr; pa_wa = r_na[VW-1:0]; pb_wa = r_nb[VW-1:0];
        tp_wd = '1; ecc_wd = r_clr; cc_wd = r_clr; sz_wd = NW'(1);
        st_wd = '0; pa_wd = r_fr; pb_wd = r_fr;
        tp_ra = r_rv; ecc_ra = r_fr; cc_ra = r_cr; sz_ra = r_cu;
        st_ra = r_fr; pa_ra = r_i[VW-1:0]; pb_ra = r_i[VW-1:0];
        o_stat.cond = 1'b0;
        o_stat.out_free = out_free;
        n_fx = r_fx; n_fr = r_fr; n_u = r_u; n_v = r_v; n_cu = r_cu; n_cv = r_cv;
        n_cr = r_cr; n_cx = r_cx; n_cy = r_cy; n_rv = r_rv; n_child = r_child;
        n_a = r_a; n_b = r_b; n_lca = r_lca; n_clr = r_clr;
        n_szu = r_szu; n_na = r_na; n_nb = r_nb; n_i = r_i; n_bridges = r_bridges;
        n_child_none = r_child_none; n_pnone = r_pnone;
        n_a_none = r_a_none; n_b_none = r_b_none;
        n_walk = r_walk; n_kind = r_kind;
        n_out_kind = r_out_kind; n_out_cnt = r_out_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (i_cmd)
            CMD_INIT: begin
                tp_we = 1'b1; ecc_we = 1'b1; cc_we = 1'b1; sz_we = 1'b1; st_we = 1'b1;
                n_clr = r_clr + 1'b1;
                o_stat.cond = clr_last;
            end
            CMD_ACCEPT: begin
                n_fx = VW'(i_first_vertex);
                n_fr = VW'(i_first_vertex);
                n_v  = VW'(i_second_vertex);
                n_kind = KIND_NONE;
                o_stat.cond = in_range;
            end
            CMD_ER_A: ecc_ra = r_fr;
            CMD_ER_B: begin
                o_stat.cond = (ecc_q == r_fr);
                if (ecc_q != r_fr) n_fr = ecc_q;
            end
            CMD_ER_C: begin
                ecc_ra = r_fx;
                o_stat.cond = (r_fx == r_fr);
            end
            CMD_ER_D: begin
                o_stat.cond = (ecc_q == r_fr);
                if (ecc_q != r_fr) begin
                    ecc_we = 1'b1; ecc_wa = r_fx; ecc_wd = r_fr;
                    n_fx = ecc_q;
                end
            end
            CMD_FU: begin
                n_u = r_fr; n_fx = r_v; n_fr = r_v;
            end
            CMD_FV: begin
                n_v = r_fr; n_cr = r_u; n_cx = r_u;
                o_stat.cond = (r_u == r_fr);
            end
            CMD_C1: cc_ra = r_cr;
            CMD_C2: begin
                o_stat.cond = (cc_q == r_cr);
                if (cc_q == r_cr) begin
                    n_cy = r_cx;
                end else begin
                    n_fx = cc_q; n_fr = cc_q;
                end
            end
            CMD_C2B: n_cr = r_fr;
            CMD_C3: cc_ra = r_cy;
            CMD_C4: begin
                o_stat.cond = (cc_q == r_cy);
                n_fx = cc_q; n_fr = cc_q;
            end
            CMD_C5: begin
                cc_we = 1'b1; cc_wa = r_cy; cc_wd = r_cr;
                n_cy = r_fr;
            end
            CMD_CU: begin
                n_cu = r_cr; n_cr = r_v; n_cx = r_v;
            end
            CMD_CV: begin
                n_cv = r_cr;
                sz_ra = r_cu;
                o_stat.cond = (r_cu == r_cr);
                if (r_cu == r_cr) begin
                    n_kind = KIND_CYCLE;
                end else begin
                    n_kind = KIND_BRIDGE;
                    n_bridges = r_bridges + 1'b1;
                end
            end
            CMD_SZ1: begin
                n_szu = sz_q; sz_ra = r_cv;
            end
            CMD_SZ2: begin
                n_child_none = 1'b1;
                o_stat.cond = (r_szu > sz_q);
                if (r_szu > sz_q) begin
                    n_u = r_v; n_v = r_u; n_cu = r_cv; n_cv = r_cu; n_rv = r_v;
                end else begin
                    n_rv = r_u;
                end
            end
            CMD_R1: tp_ra = r_rv;
            CMD_R2: begin
                o_stat.cond = tp_q[VW];
                n_pnone = tp_q[VW];
                n_fx = tp_q[VW-1:0]; n_fr = tp_q[VW-1:0];
            end
            CMD_R3: begin
                tp_we = 1'b1; tp_wa = r_rv; tp_wd = {r_child_none, r_child};
                cc_we = 1'b1; cc_wa = r_rv; cc_wd = r_u;
                n_child = r_rv; n_child_none = 1'b0;
                o_stat.cond = r_pnone;
                if (!r_pnone) n_rv = r_fr;
            end
            CMD_R4: sz_ra = r_child;
            CMD_R5: begin
                sz_we = 1'b1; sz_wa = r_u; sz_wd = sz_q;
            end
            CMD_J1: begin
                tp_we = 1'b1; tp_wa = r_u; tp_wd = {1'b0, r_v};
                cc_we = 1'b1; cc_wa = r_u; cc_wd = r_v;
                sz_ra = r_u;
            end
            CMD_J2: begin
                n_szu = sz_q; sz_ra = r_cv;
            end
            CMD_J3: begin
                sz_we = 1'b1; sz_wa = r_cv; sz_wd = sz_q + r_szu;
            end
            CMD_M0: begin
                o_stat.cond = (walk_inc == '0);
                if (walk_inc == '0) begin
                    n_walk = SB'(1); n_clr = '0;
                end else begin
                    n_walk = walk_inc;
                end
            end
            CMD_MS: begin
                st_we = 1'b1; st_wa = r_clr; st_wd = '0;
                n_clr = r_clr + 1'b1;
                o_stat.cond = clr_last;
            end
            CMD_M1: begin
                n_a = r_u; n_b = r_v; n_a_none = 1'b0; n_b_none = 1'b0;
                n_na = '0; n_nb = '0;
            end
            CMD_MA0: begin
                o_stat.cond = r_a_none;
                n_fx = r_a; n_fr = r_a;
            end
            CMD_MA1: begin
                n_a = r_fr; st_ra = r_fr;
                if (r_na < NW'(MAX_VERTICES)) begin
                    pa_we = 1'b1; pa_wa = r_na[VW-1:0]; pa_wd = r_fr;
                    n_na = r_na + 1'b1;
                end
            end
            CMD_MA2: begin
                tp_ra = r_a;
                o_stat.cond = (st_q == r_walk);
                if (st_q == r_walk) begin
                    n_lca = r_a; n_i = '0;
                end else begin
                    st_we = 1'b1; st_wa = r_a; st_wd = r_walk;
                end
            end
            CMD_MA3: begin
                n_a_none = tp_q[VW]; n_a = tp_q[VW-1:0];
            end
            CMD_MB0: begin
                o_stat.cond = r_b_none;
                n_fx = r_b; n_fr = r_b;
            end
            CMD_MB1: begin
                n_b = r_fr; st_ra = r_fr;
                if (r_nb < NW'(MAX_VERTICES)) begin
                    pb_we = 1'b1; pb_wa = r_nb[VW-1:0]; pb_wd = r_fr;
                    n_nb = r_nb + 1'b1;
                end
            end
            CMD_MB2: begin
                tp_ra = r_b;
                o_stat.cond = (st_q == r_walk);
                if (st_q == r_walk) begin
                    n_lca = r_b; n_i = '0;
                end else begin
                    st_we = 1'b1; st_wa = r_b; st_wd = r_walk;
                end
            end
            CMD_MB3: begin
                n_b_none = tp_q[VW]; n_b = tp_q[VW-1:0];
            end
            CMD_MCHK: o_stat.cond = r_a_none && r_b_none;
            CMD_PA0: begin
                pa_ra = r_i[VW-1:0];
                o_stat.cond = (r_i >= r_na);
                if (r_i >= r_na) n_i = '0;
            end
            CMD_PA1: begin
                ecc_we = 1'b1; ecc_wa = pa_q; ecc_wd = r_lca;
                o_stat.cond = (pa_q == r_lca);
                if (pa_q == r_lca) begin
                    n_i = '0;
                end else begin
                    n_bridges = drop_val; n_i = r_i + 1'b1;
                end
            end
            CMD_PB0: begin
                pb_ra = r_i[VW-1:0];
                o_stat.cond = (r_i >= r_nb);
            end
            CMD_PB1: begin
                ecc_we = 1'b1; ecc_wa = pb_q; ecc_wd = r_lca;
                o_stat.cond = (pb_q == r_lca);
                if (pb_q != r_lca) begin
                    n_bridges = drop_val; n_i = r_i + 1'b1;
                end
            end
            CMD_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = CNT_W'(r_bridges);
                    n_out_kind  = r_kind;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_walk      <= '0;
            r_bridges   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr       <= n_clr;
            r_walk      <= n_walk;
            r_bridges   <= n_bridges;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx <= n_fx; r_fr <= n_fr; r_u <= n_u; r_v <= n_v; r_cu <= n_cu; r_cv <= n_cv;
        r_cr <= n_cr; r_cx <= n_cx; r_cy <= n_cy; r_rv <= n_rv; r_child <= n_child;
        r_a <= n_a; r_b <= n_b; r_lca <= n_lca;
        r_szu <= n_szu; r_na <= n_na; r_nb <= n_nb; r_i <= n_i;
        r_child_none <= n_child_none; r_pnone <= n_pnone;
        r_a_none <= n_a_none; r_b_none <= n_b_none;
        r_kind <= n_kind; r_out_kind <= n_out_kind; r_out_cnt <= n_out_cnt;
    end

    a_bridges_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bridges < NW'(MAX_VERTICES))
        else $error("Bridge count exceeds the forest edge limit.");

    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_MA1 || i_cmd == CMD_MB1) |-> (r_walk != '0))
        else $error("Cycle walk runs with a zero stamp.");

    a_path_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_MA1) |-> (r_na <= NW'(MAX_VERTICES) && r_nb <= NW'(MAX_VERTICES)))
        else $error("Path buffer length out of range.");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_DONE && out_free) |=> o_out_valid)
        else $error("Finished request did not reach the output register.");

endmodule

`default_nettype wire

// ===== src/online_bridge_counter.sv =====
// Top level of the online bridge counter.
// Joins the controller obc_ctrl and the datapath obc_dp; uses obc_pkg.
//
// Each in-range request adds one undirected edge; every request yields one result: the
// bridge count after it and its kind (inside a bridge-free component, new bridge,
// or closed cycle). After reset the block runs a clearing pass over its memories before it
// takes the first request. The time an edge takes depends on the data: every union-find step,
// tree-path step and path-buffer step is one access to a memory with separate write and read
// ports and registered read data; rerooting visits each tree node in turn, and a cycle merge
// walks up the tree and then replays the stored path.
// When the visit stamp wraps, the stamp memory is swept clear before the walk goes on.
// A finished result waits in an output register while the next request is accepted.
`default_nettype none

module online_bridge_counter
    import obc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int STAMP_BITS   = DEF_STAMP_BITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire [VTX_W-1:0]   i_first_vertex,
    input  wire [VTX_W-1:0]   i_second_vertex,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [CNT_W-1:0]  o_bridge_count,
    output logic [KIND_W-1:0] o_edge_kind
);

    t_cmd  cmd;
    t_stat stat;

    obc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    obc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .STAMP_BITS   (STAMP_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_bridge_count  (o_bridge_count),
        .o_edge_kind     (o_edge_kind)
    );

endmodule

`default_nettype wire

// ===== test/online_bridge_counter_tb.sv =====
// Self-checking testbench for online_bridge_counter, built with a 5-bit stamp so that wraps occur.
// Holds its own bridge-tracking predictor and drives directed and random edges with idling on both sides.
// Depends on obc_pkg and the online_bridge_counter RTL.
`timescale 1ns / 100ps

module online_bridge_counter_tb;
    import obc_pkg::*;

    localparam int NV         = DEF_MAX_VERTICES;
    localparam int TB_STAMP_W = 5;
    localparam int LIMIT      = 1500000;
    localparam logic [10:0] NO_PARENT = 11'h7FF;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [KIND_W-1:0] kind;
    } t_edge_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [VTX_W-1:0]  first_vtx;
    logic [VTX_W-1:0]  second_vtx;
    logic              out_valid;
    logic              out_stall;
    logic [CNT_W-1:0]  bridge_count;
    logic [KIND_W-1:0] edge_kind;

    online_bridge_counter #(.MAX_VERTICES(NV), .STAMP_BITS(TB_STAMP_W)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_first_vertex (first_vtx),
        .i_second_vertex(second_vtx),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_bridge_count (bridge_count),
        .o_edge_kind    (edge_kind)
    );

    // Predictor state.
    logic [10:0]       tree_up   [NV];
    logic [9:0]        ecc_up    [NV];
    logic [9:0]        cc_up     [NV];
    logic [10:0]       comp_cnt  [NV];
    logic [15:0]       seen_mark [NV];
    logic [15:0]       walk_no;
    logic [CNT_W-1:0]  bridges;
    int                trail_a   [NV];
    int                trail_b   [NV];

    t_edge_result expected_results[$];
    int  errors;
    int  cycles;
    int  kind_seen[3];
    bit  src_gaps;
    bit  sink_gaps;
    bit  hold_req;
    int  long_holds;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
            $display("online_bridge_counter_tb: errors");
            $finish;
        end
    end

    function automatic int find_ecc(int x);
        int r;
        int nxt;
        r = x;
        while (ecc_up[r] != r) r = ecc_up[r];
        while (ecc_up[x] != r && x != r) begin
            nxt = ecc_up[x];
            ecc_up[x] = r;
            x = nxt;
        end
        return r;
    endfunction

    function automatic int find_cc(int x);
        int r;
        int y;
        int nxt;
        r = find_ecc(x);
        while (cc_up[r] != r) r = find_ecc(cc_up[r]);
        y = find_ecc(x);
        while (cc_up[y] != y) begin
            nxt = find_ecc(cc_up[y]);
            cc_up[y] = r;
            y = nxt;
        end
        return r;
    endfunction

    function automatic int parent_of(int x);
        return (tree_up[x] == NO_PARENT) ? -1 : int'(tree_up[x]);
    endfunction

    function automatic void hang_tree(int v);
        int root;
        int child;
        int p;
        v = find_ecc(v);
        root = v;
        child = -1;
        while (v >= 0) begin
            p = (parent_of(v) < 0) ? -1 : find_ecc(parent_of(v));
            tree_up[v] = (child < 0) ? NO_PARENT : 11'(child);
            cc_up[v] = 10'(root);
            child = v;
            v = p;
        end
        if (child >= 0) comp_cnt[root] = comp_cnt[child];
    endfunction

    function automatic void collapse_cycle(int a, int b);
        int lca;
        int na;
        int nb;
        lca = -1;
        na = 0;
        nb = 0;
        walk_no = (walk_no + 1) & ((1 << TB_STAMP_W) - 1);
        if (walk_no == 0) begin
            foreach (seen_mark[i]) seen_mark[i] = '0;
            walk_no = 1;
        end
        while (lca < 0) begin
            if (a < 0 && b < 0) break;
            if (a >= 0) begin
                a = find_ecc(a);
                if (na < NV) trail_a[na++] = a;
                if (seen_mark[a] == walk_no) begin
                    lca = a;
                    break;
                end
                seen_mark[a] = walk_no;
                a = parent_of(a);
            end
            if (b >= 0) begin
                b = find_ecc(b);
                if (nb < NV) trail_b[nb++] = b;
                if (seen_mark[b] == walk_no) begin
                    lca = b;
                    break;
                end
                seen_mark[b] = walk_no;
                b = parent_of(b);
            end
        end
        if (lca < 0) return;
        for (int i = 0; i < na; i++) begin
            ecc_up[trail_a[i]] = 10'(lca);
            if (trail_a[i] == lca) break;
            if (bridges > 0) bridges--;
        end
        for (int i = 0; i < nb; i++) begin
            ecc_up[trail_b[i]] = 10'(lca);
            if (trail_b[i] == lca) break;
            if (bridges > 0) bridges--;
        end
    endfunction

    function automatic t_edge_result predict_edge(int a, int b);
        t_edge_result res;
        int u;
        int v;
        int cu;
        int cv;
        int t;
        res.kind = KIND_NONE;
        u = find_ecc(a);
        v = find_ecc(b);
        if (u != v) begin
            cu = find_cc(u);
            cv = find_cc(v);
            if (cu != cv) begin
                res.kind = KIND_BRIDGE;
                bridges++;
                if (comp_cnt[cu] > comp_cnt[cv]) begin
                    t = u; u = v; v = t;
                    t = cu; cu = cv; cv = t;
                end
                hang_tree(u);
                tree_up[u] = 11'(v);
                cc_up[u] = 10'(v);
                comp_cnt[cv] = comp_cnt[cv] + comp_cnt[u];
            end else begin
                res.kind = KIND_CYCLE;
                collapse_cycle(u, v);
            end
        end
        res.count = bridges;
        return res;
    endfunction

    task automatic send_edge(int a, int b);
        @(negedge i_clk);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        first_vtx  <= VTX_W'(a);
        second_vtx <= VTX_W'(b);
        do @(posedge i_clk); while (!(in_valid && !in_stall));
        expected_results.insert(expected_results.size(), predict_edge(a, b));
    endtask

    // Receiver side: random stall bursts, or one long hold when asked.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (600) @(negedge i_clk);
                hold_req = 1'b0;
                long_holds++;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result count=%0d kind=%0d", $time, bridge_count,
                         edge_kind);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (bridge_count !== want.count) begin
                    $display("%0t: bridge_count expected %0d actual %0d", $time, want.count,
                             bridge_count);
                    errors++;
                end
                if (edge_kind !== want.kind) begin
                    $display("%0t: edge_kind expected %0d actual %0d", $time, want.kind,
                             edge_kind);
                    errors++;
                end
                if (want.kind <= KIND_CYCLE) kind_seen[want.kind]++;
            end
        end
    end

    task automatic test_directed();
        send_edge(0, 0);
        send_edge(1023, 0);
        send_edge(0, 1023);
        send_edge(1023, 0);
        send_edge(5, 6);
        send_edge(6, 7);
        send_edge(8, 9);
        send_edge(7, 8);
        send_edge(9, 5);
        send_edge(7, 7);
        send_edge(512, 511);
        send_edge(341, 682);
        send_edge(682, 511);
        send_edge(341, 1023);
        send_edge(512, 5);
        send_edge(1, 2);
        send_edge(2, 3);
        send_edge(3, 4);
        send_edge(4, 1);
        send_edge(2, 4);
    endtask

    task automatic test_small_pool(int n);
        int base;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) base = $urandom_range(0, NV - 32);
            send_edge(base + $urandom_range(0, 31), base + $urandom_range(0, 31));
        end
    endtask

    task automatic test_chains(int n);
        int sent;
        int base;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 4) == 0) begin
                send_edge($urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
                sent++;
            end else begin
                len = $urandom_range(3, 20);
                base = $urandom_range(0, NV - 1 - len);
                for (int k = 0; k < len; k++) send_edge(base + k, base + k + 1);
                send_edge(base + $urandom_range(0, len), base + $urandom_range(0, len));
                sent += len + 1;
            end
        end
    endtask

    task automatic test_backpressure(int n);
        src_gaps  = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < n; i++)
            send_edge($urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
        src_gaps  = 1'b1;
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        long_holds = 0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        hold_req   = 1'b0;
        kind_seen  = '{0, 0, 0};
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        first_vtx  = '0;
        second_vtx = '0;
        for (int i = 0; i < NV; i++) begin
            tree_up[i]   = NO_PARENT;
            ecc_up[i]    = 10'(i);
            cc_up[i]     = 10'(i);
            comp_cnt[i]  = 11'd1;
            seen_mark[i] = '0;
        end
        walk_no = '0;
        bridges = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_small_pool(150);
        test_chains(200);
        test_backpressure(40);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_small_pool(60);
        test_chains(80);
        @(negedge i_clk);
        in_valid <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Edges inside one component %0d, new bridges %0d, cycles closed %0d.",
                 kind_seen[KIND_NONE], kind_seen[KIND_BRIDGE], kind_seen[KIND_CYCLE]);
        $display("Final bridge total %0d after %0d cycles, %0d long receiver hold(s).",
                 bridges, cycles, long_holds);
        if (errors == 0) begin
            $display("online_bridge_counter_tb: clean");
        end else begin
            $display("online_bridge_counter_tb: errors");
        end
        $finish;
    end

endmodule
